/* hdl/fctb_pkg.sv */
// Package for the fair-coin to biased-tile decoder.
// Widths, default parameter values, register indexes and reset values.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fctb_pkg;

	// Default fixed-point format Q8.24 and forced zoom point
	localparam int FRAC_BITS_DEF = 24;
	localparam int INT_BITS_DEF = 8;
	localparam int MAX_COINS_DEF = 16;

	// Counter and register widths
	localparam int COIN_CNT_W = 5;
	localparam int TILE_CNT_W = 6;
	localparam int TILE_NUM_W = 7;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 6;

	// At most this many tiles per item
	localparam logic [TILE_NUM_W-1:0] TILE_CAP = 7'd64;

	// Register reset values
	localparam logic [COIN_CNT_W-1:0] COIN_LIMIT_RST = 5'd5;
	localparam logic [TILE_CNT_W-1:0] TILE_LIMIT_RST = 6'd20;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_COIN_LIMIT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_TILE_LIMIT = 1'b1;

	// Bits of the dividend retired per cycle by the divide-by-six unit
	localparam int DIV_STEP_BITS = 8;

endpackage

`default_nettype wire

/* hdl/fair_coin_to_biased_tile_decoder_core.sv */
// Fair-coin to biased-tile decoder, top level: sequencer, interval state, registers.
// One item at a time. A restart goes straight to the final item; a coin walks its
// tiles, then finishes, zooms three values when due and emits. The divide-by-six unit
// computes each split in ITERS = ceil((INT_BITS+FRAC_BITS+5)/8) steps, 5 at Q8.24.
// Reset (arst_n low, asynchronous) clears the interval state and loads register defaults.
// Depends on fctb_pkg, fctb_div6, fctb_zoom.
`timescale 1ns / 1ps
`default_nettype none

module fair_coin_to_biased_tile_decoder_core
	import fctb_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF,
	parameter int INT_BITS = INT_BITS_DEF,
	parameter int MAX_COINS_PER_ZOOM = MAX_COINS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// coin channel
	input  wire logic                  coin_valid,
	output logic                       coin_stall,
	input  wire logic                  func,
	input  wire logic                  heads,
	// result channel
	output logic                       res_valid,
	input  wire logic                  res_stall,
	output logic                       tile_valid,
	output logic                       tile_bronze,
	output logic                       last,
	output logic                       zoomed,
	output logic                       overflow,
	// configuration write channel
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int FX_W = INT_BITS + FRAC_BITS;
	localparam int NW = FX_W + 4;
	localparam int MAXC = MAX_COINS_PER_ZOOM;
	localparam int LW = (MAXC + 1 + FRAC_BITS > FX_W + 1) ? (MAXC + 1 + FRAC_BITS) : (FX_W + 1);
	localparam logic signed [FX_W-1:0] FX_ONE = FX_W'(64'd1 << FRAC_BITS);
	localparam logic signed [FX_W-1:0] SPLIT0 = FX_W'(((64'd1 << FRAC_BITS) * 64'd5) / 64'd6);
	localparam logic signed [NW-1:0] FX_MAX_N = {{(NW-FX_W+1){1'b0}}, {(FX_W-1){1'b1}}};
	localparam logic signed [NW-1:0] FX_MIN_N = ~FX_MAX_N;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CMP,
		ST_SPAN,
		ST_DIVGO,
		ST_DIVWAIT,
		ST_FINISH,
		ST_ZOOM,
		ST_EMIT
	} state_t;

	state_t                  state_q;
	logic [MAXC-1:0]         lbb_q;
	logic [COIN_CNT_W-1:0]   coins_q;
	logic [TILE_CNT_W-1:0]   tiles_q;
	logic                    flag_q;
	logic signed [FX_W-1:0]  rb_q;
	logic signed [FX_W-1:0]  rt_q;
	logic signed [FX_W-1:0]  rs_q;
	logic [TILE_NUM_W-1:0]   n_q;
	logic                    pend_q;
	logic                    pend_bronze_q;
	logic                    zoomed_q;
	logic                    ovf_q;
	logic [1:0]              zidx_q;
	logic signed [NW-1:0]    num_q;
	logic [COIN_CNT_W-1:0]   coin_lim_q;
	logic [TILE_CNT_W-1:0]   tile_lim_q;

	logic                    res_valid_q;
	logic                    tile_valid_q;
	logic                    tile_bronze_q;
	logic                    last_q;
	logic                    zoomed_out_q;
	logic                    overflow_q;

	logic [LW-1:0]           lb_wide;
	logic [LW-1:0]           lt_wide;
	logic [FX_W:0]           lb_fx;
	logic [FX_W:0]           lt_fx;
	logic                    is_bronze;
	logic                    is_gold;
	logic                    out_free;
	logic                    res_load;
	logic                    zoom_due;
	logic signed [NW-1:0]    span_d;
	logic                    div_start;
	logic                    div_done;
	logic signed [NW-1:0]    div_quo;
	logic signed [NW-1:0]    split_sum;
	logic signed [FX_W-1:0]  split_new;
	logic signed [FX_W-1:0]  zoom_in;
	logic signed [FX_W-1:0]  zoom_val;
	logic                    zoom_ovf;

	// Left interval ends in fixed point: bits / 2^coins
	assign lb_wide = LW'({1'b0, lbb_q, {FRAC_BITS{1'b0}}}) >> coins_q;
	assign lt_wide = LW'({(MAXC+1)'({1'b0, lbb_q}) + (MAXC+1)'(1), {FRAC_BITS{1'b0}}}) >> coins_q;
	assign lb_fx = lb_wide[FX_W:0];
	assign lt_fx = lt_wide[FX_W:0];

	// Tile tests against the split
	assign is_bronze = $signed({1'b0, lt_fx}) <= (FX_W+2)'(rs_q);
	assign is_gold = $signed({1'b0, lb_fx}) >= (FX_W+2)'(rs_q);

	assign out_free = !res_valid_q || !res_stall;

	// Result register loads: an earlier tile while the pass goes on, or the final item
	assign res_load = ((state_q == ST_CMP) && !(n_q == TILE_CAP || (!is_bronze && !is_gold)) &&
		pend_q && out_free) || ((state_q == ST_EMIT) && out_free);

	assign zoom_due = (coins_q >= COIN_CNT_W'(MAXC)) ||
		(flag_q && ((coins_q >= coin_lim_q) || (tiles_q > tile_lim_q)));

	// Width of the right interval
	assign span_d = NW'(rt_q) - NW'(rb_q);

	// New split: bottom + floor(5 * width / 6), clamped
	assign split_sum = NW'(rb_q) + div_quo;
	always_comb begin
		split_new = split_sum[FX_W-1:0];
		if (split_sum > FX_MAX_N) begin
			split_new = FX_MAX_N[FX_W-1:0];
		end else if (split_sum < FX_MIN_N) begin
			split_new = FX_MIN_N[FX_W-1:0];
		end
	end

	assign div_start = (state_q == ST_DIVGO);

	fctb_div6 #(
		.NW(NW)
	) u_div6 (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.num(num_q),
		.done(div_done),
		.quo(div_quo)
	);

	// Shared zoom unit, one right value per cycle
	always_comb begin
		case (zidx_q)
			2'd0: zoom_in = rt_q;
			2'd1: zoom_in = rb_q;
			default: zoom_in = rs_q;
		endcase
	end

	fctb_zoom #(
		.FRAC_BITS(FRAC_BITS),
		.INT_BITS(INT_BITS)
	) u_zoom (
		.r(zoom_in),
		.lb(lb_fx),
		.c(coins_q),
		.val(zoom_val),
		.ovf(zoom_ovf)
	);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coin_lim_q <= COIN_LIMIT_RST;
			tile_lim_q <= TILE_LIMIT_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_COIN_LIMIT: coin_lim_q <= cfg_data[COIN_CNT_W-1:0];
				CFG_TILE_LIMIT: tile_lim_q <= cfg_data[TILE_CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// Sequencer, interval state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			lbb_q <= '0;
			coins_q <= '0;
			tiles_q <= '0;
			flag_q <= 1'b0;
			rb_q <= '0;
			rt_q <= FX_ONE;
			rs_q <= SPLIT0;
			n_q <= '0;
			pend_q <= 1'b0;
			pend_bronze_q <= 1'b0;
			zoomed_q <= 1'b0;
			ovf_q <= 1'b0;
			zidx_q <= '0;
			num_q <= '0;
			res_valid_q <= 1'b0;
			tile_valid_q <= 1'b0;
			tile_bronze_q <= 1'b0;
			last_q <= 1'b0;
			zoomed_out_q <= 1'b0;
			overflow_q <= 1'b0;
		end else begin
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && !res_stall) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (coin_valid) begin
						zoomed_q <= 1'b0;
						ovf_q <= 1'b0;
						n_q <= '0;
						if (func) begin
							lbb_q <= '0;
							coins_q <= '0;
							tiles_q <= '0;
							flag_q <= 1'b0;
							rb_q <= '0;
							rt_q <= FX_ONE;
							rs_q <= SPLIT0;
							state_q <= ST_EMIT;
						end else begin
							lbb_q <= {lbb_q[MAXC-2:0], heads};
							coins_q <= coins_q + COIN_CNT_W'(1);
							state_q <= ST_CMP;
						end
					end
				end
				ST_CMP: begin
					if (n_q == TILE_CAP || (!is_bronze && !is_gold)) begin
						state_q <= ST_FINISH;
					end else if (!pend_q || out_free) begin
						// earlier tile goes out as a non-final result
						if (pend_q) begin
							tile_valid_q <= 1'b1;
							tile_bronze_q <= pend_bronze_q;
							last_q <= 1'b0;
							zoomed_out_q <= 1'b0;
							overflow_q <= 1'b0;
						end
						if (is_bronze) begin
							rt_q <= rs_q;
						end else begin
							rb_q <= rs_q;
						end
						pend_q <= 1'b1;
						pend_bronze_q <= is_bronze;
						flag_q <= 1'b1;
						if (tiles_q != '1) begin
							tiles_q <= tiles_q + TILE_CNT_W'(1);
						end
						n_q <= n_q + TILE_NUM_W'(1);
						state_q <= ST_SPAN;
					end
				end
				ST_SPAN: begin
					num_q <= (span_d <<< 2) + span_d;
					state_q <= ST_DIVGO;
				end
				ST_DIVGO: begin
					state_q <= ST_DIVWAIT;
				end
				ST_DIVWAIT: begin
					if (div_done) begin
						rs_q <= split_new;
						state_q <= ST_CMP;
					end
				end
				ST_FINISH: begin
					zidx_q <= '0;
					state_q <= zoom_due ? ST_ZOOM : ST_EMIT;
				end
				ST_ZOOM: begin
					case (zidx_q)
						2'd0: rt_q <= zoom_val;
						2'd1: rb_q <= zoom_val;
						default: rs_q <= zoom_val;
					endcase
					if (zoom_ovf) begin
						ovf_q <= 1'b1;
					end
					zidx_q <= zidx_q + 2'd1;
					if (zidx_q == 2'd2) begin
						lbb_q <= '0;
						coins_q <= '0;
						tiles_q <= '0;
						flag_q <= 1'b0;
						zoomed_q <= 1'b1;
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					// final result of the item
					if (out_free) begin
						tile_valid_q <= pend_q;
						tile_bronze_q <= pend_q && pend_bronze_q;
						last_q <= 1'b1;
						zoomed_out_q <= zoomed_q;
						overflow_q <= ovf_q;
						pend_q <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign coin_stall = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign res_valid = res_valid_q;
	assign tile_valid = tile_valid_q;
	assign tile_bronze = tile_bronze_q;
	assign last = last_q;
	assign zoomed = zoomed_out_q;
	assign overflow = overflow_q;

endmodule

`default_nettype wire

/* hdl/fctb_div6.sv */
// Iterative signed floor division by six, DIV_STEP_BITS bits per cycle.
// Depends on fctb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fctb_div6
	import fctb_pkg::*;
#(
	parameter int NW = 36
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic signed [NW-1:0] num,
	output logic                      done,
	output logic signed [NW-1:0]      quo
);

	localparam int R = DIV_STEP_BITS;
	localparam int MW = NW + 1;
	localparam int ITERS = (MW + R - 1) / R;
	localparam int NP = ITERS * R;
	localparam int CW = $clog2(ITERS + 1);

	logic [NP-1:0] mag_q;
	logic [NP-1:0] quo_q;
	logic [2:0]    rem_q;
	logic          neg_q;
	logic [CW-1:0] cnt_q;
	logic          done_q;

	logic [MW-1:0] mag_n;
	logic [R-1:0]  chunk;
	logic [R-1:0]  qbits;
	logic [2:0]    rem_n;

	// Magnitude to divide: floor for negatives is minus ceil of the magnitude
	assign mag_n = num[NW-1] ? ({1'b0, ~num} + MW'(6)) : {1'b0, num};

	// R restoring steps of a remainder-mod-six walk, most significant bit first
	always_comb begin
		logic [3:0] t;
		chunk = mag_q[NP-1 -: R];
		rem_n = rem_q;
		qbits = '0;
		for (int j = R - 1; j >= 0; j--) begin
			t = {rem_n, chunk[j]};
			if (t >= 4'd6) begin
				rem_n = 3'(t - 4'd6);
				qbits[j] = 1'b1;
			end else begin
				rem_n = t[2:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mag_q <= '0;
			quo_q <= '0;
			rem_q <= '0;
			neg_q <= 1'b0;
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				mag_q <= NP'(mag_n);
				quo_q <= '0;
				rem_q <= '0;
				neg_q <= num[NW-1];
				cnt_q <= CW'(ITERS);
			end else if (cnt_q != '0) begin
				mag_q <= mag_q << R;
				quo_q <= {quo_q[NP-R-1:0], qbits};
				rem_q <= rem_n;
				cnt_q <= cnt_q - CW'(1);
				done_q <= (cnt_q == CW'(1));
			end
		end
	end

	assign done = done_q;
	assign quo = neg_q ? (~quo_q[NW-1:0] + NW'(1)) : quo_q[NW-1:0];

endmodule

`default_nettype wire

/* hdl/fctb_zoom.sv */
// Saturating zoom of one right-interval value: (r - left_bottom) * 2^c.
// Depends on fctb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fctb_zoom
	import fctb_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF,
	parameter int INT_BITS = INT_BITS_DEF
) (
	input  wire logic signed [INT_BITS+FRAC_BITS-1:0] r,
	input  wire logic [INT_BITS+FRAC_BITS:0]          lb,
	input  wire logic [COIN_CNT_W-1:0]                c,
	output logic signed [INT_BITS+FRAC_BITS-1:0]      val,
	output logic                                      ovf
);

	localparam int FX_W = INT_BITS + FRAC_BITS;
	localparam int SW = FX_W + 2 + (2 ** COIN_CNT_W) - 1;
	localparam logic signed [SW-1:0] MAX_S = {{(SW-FX_W+1){1'b0}}, {(FX_W-1){1'b1}}};
	localparam logic signed [SW-1:0] MIN_S = ~MAX_S;

	logic signed [FX_W+1:0] diff;
	logic signed [SW-1:0]   scaled;

	assign diff = (FX_W+2)'(r) - $signed({1'b0, lb});
	assign scaled = SW'(diff) <<< c;

	// Clamp to the signed fixed-point range
	always_comb begin
		ovf = 1'b0;
		val = scaled[FX_W-1:0];
		if (scaled > MAX_S) begin
			ovf = 1'b1;
			val = MAX_S[FX_W-1:0];
		end else if (scaled < MIN_S) begin
			ovf = 1'b1;
			val = MIN_S[FX_W-1:0];
		end
	end

endmodule

`default_nettype wire
